/* rtl/midi_note_priority_tracker_defines.svh */
`ifndef MIDI_NOTE_PRIORITY_TRACKER_DEFINES_SVH
`define MIDI_NOTE_PRIORITY_TRACKER_DEFINES_SVH

// Same-cycle implication checked on every rising edge outside reset.
`define MNPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define MNPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mnpt_pkg.sv */
`default_nettype none

package mnpt_pkg;

  localparam int unsigned NoteLimit = 128;
  localparam int unsigned NoteW     = 7;
  localparam int unsigned CountW    = 8;

  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;

  localparam logic [2:0] ACT_IGNORE      = 3'd0;
  localparam logic [2:0] ACT_TRIGGER     = 3'd1;
  localparam logic [2:0] ACT_SLIDE       = 3'd2;
  localparam logic [2:0] ACT_RELEASE_ALL = 3'd3;
  localparam logic [2:0] ACT_FALL_BACK   = 3'd4;
  localparam logic [2:0] ACT_POLY_OFF    = 3'd5;

  localparam logic [2:0] CLS_IGNORE   = 3'd0;
  localparam logic [2:0] CLS_POLY_ON  = 3'd1;
  localparam logic [2:0] CLS_POLY_OFF = 3'd2;
  localparam logic [2:0] CLS_ON       = 3'd3;
  localparam logic [2:0] CLS_ON_FULL  = 3'd4;
  localparam logic [2:0] CLS_OFF      = 3'd5;

  typedef struct packed {
    logic       message_is_data;
    logic [7:0] status_byte;
    logic [7:0] note_number;
    logic [7:0] velocity;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        action_code;
    logic [NoteW-1:0]  target_note;
    logic [CountW-1:0] held_count;
  } out_word_t;

  typedef struct packed {
    logic load_in;
    logic decode;
    logic scan_step;
    logic scan_finish;
    logic tail_read;
    logic tail_capture;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] cls;
    logic       scan_done;
    logic       tail_needed;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/mnpt_ctrl.sv */
`default_nettype none

module mnpt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire mnpt_pkg::sts_t sts,
  output mnpt_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DECODE    = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_TAIL      = 3'd3;
  localparam logic [2:0] S_TAIL_WAIT = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.cls == mnpt_pkg::CLS_ON_FULL || sts.cls == mnpt_pkg::CLS_OFF) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.scan_finish = 1'b1;
          state_next      = sts.tail_needed ? S_TAIL : S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_TAIL: begin
        cmd.tail_read = 1'b1;
        state_next    = S_TAIL_WAIT;
      end
      S_TAIL_WAIT: begin
        cmd.tail_capture = 1'b1;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    priority if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/mnpt_datapath.sv */
`default_nettype none

module mnpt_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  input  wire mnpt_pkg::in_word_t in_word,
  input  wire mnpt_pkg::cmd_t     cmd,
  output mnpt_pkg::sts_t          sts,
  output mnpt_pkg::out_word_t     out_word
);

  logic                               mono_legato;
  logic [mnpt_pkg::NoteLimit-1:0]     active_map;
  logic [mnpt_pkg::CountW-1:0]        held_count;
  mnpt_pkg::in_word_t                 in_q;
  logic [2:0]                         op_q;
  logic                               found;
  logic [mnpt_pkg::CountW-1:0]        scan_addr;
  logic [mnpt_pkg::NoteW-1:0]         rd_addr;
  logic                               rd_valid;
  mnpt_pkg::out_word_t                res;
  mnpt_pkg::out_word_t                out_q;

  logic [mnpt_pkg::NoteW-1:0] held_mem [mnpt_pkg::NoteLimit];
  logic [mnpt_pkg::NoteW-1:0] rdata;

  logic [mnpt_pkg::NoteW-1:0]  note;
  logic [3:0]                  kind;
  logic                        is_on;
  logic                        is_off;
  logic [2:0]                  cls;
  logic [mnpt_pkg::CountW-1:0] new_count;
  logic [mnpt_pkg::CountW-1:0] count_m1;
  logic [mnpt_pkg::CountW-1:0] count_p1;
  logic [mnpt_pkg::NoteW-1:0]  mem_raddr;
  logic                        mem_we;
  logic [mnpt_pkg::NoteW-1:0]  mem_waddr;
  logic [mnpt_pkg::NoteW-1:0]  mem_wdata;

  assign note      = in_q.note_number[mnpt_pkg::NoteW-1:0];
  assign kind      = in_q.status_byte[7:4];
  assign is_on     = (kind == mnpt_pkg::KIND_NOTE_ON) && (in_q.velocity != 8'd0);
  assign is_off    = (kind == mnpt_pkg::KIND_NOTE_OFF) ||
                     ((kind == mnpt_pkg::KIND_NOTE_ON) && (in_q.velocity == 8'd0));
  assign new_count = held_count - {{(mnpt_pkg::CountW-1){1'b0}}, found};
  assign count_m1  = held_count - 8'd1;
  assign count_p1  = held_count + 8'd1;

  always_comb begin
    priority if (!in_q.message_is_data || in_q.note_number[7]) begin
      cls = mnpt_pkg::CLS_IGNORE;
    end else if (is_on) begin
      if (active_map[note]) begin
        cls = mnpt_pkg::CLS_IGNORE;
      end else if (!mono_legato) begin
        cls = mnpt_pkg::CLS_POLY_ON;
      end else if (held_count[mnpt_pkg::CountW-1]) begin
        cls = mnpt_pkg::CLS_ON_FULL;
      end else begin
        cls = mnpt_pkg::CLS_ON;
      end
    end else if (is_off) begin
      cls = mono_legato ? mnpt_pkg::CLS_OFF : mnpt_pkg::CLS_POLY_OFF;
    end else begin
      cls = mnpt_pkg::CLS_IGNORE;
    end
  end

  assign sts.cls         = cls;
  assign sts.scan_done   = (scan_addr >= held_count) && !rd_valid;
  assign sts.tail_needed = (op_q == mnpt_pkg::CLS_OFF) && (new_count != '0);

  assign mem_raddr = cmd.tail_read ? count_m1[mnpt_pkg::NoteW-1:0]
                                   : scan_addr[mnpt_pkg::NoteW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = held_count[mnpt_pkg::NoteW-1:0];
    mem_wdata = note;
    priority if (cmd.decode && cls == mnpt_pkg::CLS_ON) begin
      mem_we = 1'b1;
    end else if (cmd.scan_step && rd_valid && found) begin
      mem_we    = 1'b1;
      mem_waddr = rd_addr - 7'd1;
      mem_wdata = rdata;
    end else if (cmd.scan_finish && op_q == mnpt_pkg::CLS_ON_FULL) begin
      mem_we    = 1'b1;
      mem_waddr = '1;
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      held_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= held_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mono_legato <= 1'b0;
      active_map  <= '0;
      held_count  <= '0;
      rd_valid    <= 1'b0;
      found       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mono_legato <= cfg_wr_data;
      end
      if (cmd.decode) begin
        found    <= (cls == mnpt_pkg::CLS_ON_FULL);
        rd_valid <= 1'b0;
        unique case (cls)
          mnpt_pkg::CLS_POLY_ON, mnpt_pkg::CLS_ON_FULL: begin
            active_map[note] <= 1'b1;
          end
          mnpt_pkg::CLS_ON: begin
            active_map[note] <= 1'b1;
            held_count       <= count_p1;
          end
          mnpt_pkg::CLS_POLY_OFF, mnpt_pkg::CLS_OFF: begin
            active_map[note] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan_step) begin
        if (scan_addr < held_count) begin
          rd_valid <= 1'b1;
        end else begin
          rd_valid <= 1'b0;
        end
        if (rd_valid && !found && rdata == note) begin
          found <= 1'b1;
        end
      end
      if (cmd.scan_finish && op_q == mnpt_pkg::CLS_OFF) begin
        held_count <= new_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_q <= in_word;
    end
    if (cmd.decode) begin
      op_q      <= cls;
      scan_addr <= (cls == mnpt_pkg::CLS_ON_FULL) ? 8'd1 : 8'd0;
      unique case (cls)
        mnpt_pkg::CLS_POLY_ON: begin
          res <= '{mnpt_pkg::ACT_TRIGGER, note, held_count};
        end
        mnpt_pkg::CLS_ON: begin
          res <= '{(held_count == '0) ? mnpt_pkg::ACT_TRIGGER : mnpt_pkg::ACT_SLIDE,
                   note, count_p1};
        end
        mnpt_pkg::CLS_POLY_OFF: begin
          res <= '{mnpt_pkg::ACT_POLY_OFF, note, held_count};
        end
        default: begin
          res <= '{mnpt_pkg::ACT_IGNORE, '0, held_count};
        end
      endcase
    end
    if (cmd.scan_step && scan_addr < held_count) begin
      scan_addr <= scan_addr + 8'd1;
      rd_addr   <= scan_addr[mnpt_pkg::NoteW-1:0];
    end
    if (cmd.scan_finish) begin
      if (op_q == mnpt_pkg::CLS_ON_FULL) begin
        res <= '{mnpt_pkg::ACT_SLIDE, note, held_count};
      end else begin
        res <= '{(new_count == '0) ? mnpt_pkg::ACT_RELEASE_ALL : mnpt_pkg::ACT_FALL_BACK,
                 note, new_count};
      end
    end
    if (cmd.tail_capture) begin
      res.target_note <= rdata;
    end
    if (cmd.out_load) begin
      out_q <= res;
    end
  end

  assign out_word = out_q;

endmodule

`default_nettype wire

/* rtl/midi_note_priority_tracker.sv */
// MIDI note priority tracker. One word in on the in channel (valid/ready) gives
// exactly one word out on the out channel (valid/ready), in order.
// The mono_legato register must be written through cfg_wr_en/cfg_wr_data only
// while idle; the block itself does not enforce this. Ignored messages,
// polyphonic events and mono note-ons that find room in the held list go
// from the decode state straight to the output register.
// A mono note-off scans the held list, one memory entry per cycle, and shifts
// the entries after the match down as it goes. A mono note-on that finds the
// list full drops the oldest entry the same way. The scan over the held-list
// memory, with one read port and one write port, sets the worst case.
// A new word is accepted the cycle after the previous result enters the
// output register, so input goes on while that result waits to be taken.
// When the receiver stalls, the output word holds until taken and a finished
// result waits in the block, which then accepts nothing more.
// Synchronous reset clears the mode, the active-note map and the held count;
// the held-list memory needs no clearing since only entries below the count
// are ever read.
`default_nettype none

module midi_note_priority_tracker (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire mnpt_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output mnpt_pkg::out_word_t      out_word
);

  mnpt_pkg::cmd_t cmd;
  mnpt_pkg::sts_t sts;

  mnpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mnpt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_word     (in_word),
    .cmd         (cmd),
    .sts         (sts),
    .out_word    (out_word)
  );

endmodule

`default_nettype wire

/* rtl/mnpt_checker.sv */
`default_nettype none
`include "midi_note_priority_tracker_defines.svh"

module mnpt_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire mnpt_pkg::out_word_t out_word
);

  `MNPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "output word changed while stalled")
  `MNPT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input accepted on back-to-back cycles")
  `MNPT_ASSERT_NOW(a_ignore_target, out_valid && out_word.action_code == mnpt_pkg::ACT_IGNORE, out_word.target_note == '0, "ignored word carries a note")
  `MNPT_ASSERT_NOW(a_release_empty, out_valid && out_word.action_code == mnpt_pkg::ACT_RELEASE_ALL, out_word.held_count == '0, "release all with notes still held")
  `MNPT_ASSERT_NOW(a_count_range, out_valid, out_word.held_count <= 8'd128, "held count out of range")

endmodule

bind midi_note_priority_tracker mnpt_checker u_mnpt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire
